// ----- rtl/core/dss_pkg.sv -----
// Shared types and constants for the dual stack block.
`default_nettype none

package dss_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic [1:0] t_cmd;
    typedef logic [1:0] t_status;

    localparam t_cmd CMD_PUSH      = 2'd0;
    localparam t_cmd CMD_POP_SMALL = 2'd1;
    localparam t_cmd CMD_POP_LARGE = 2'd2;
    localparam t_cmd CMD_QUERY     = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] THRESHOLD_RESET = 32'sd1000;
    localparam logic [DATA_W-1:0]        EMPTY_TOP       = '1;

endpackage

`default_nettype wire

// ----- rtl/core/dss_mem.sv -----
// Stack array: one write port and two registered read ports.
`default_nettype none

module dss_mem #(
    parameter int unsigned DEPTH       = 256,
    parameter int unsigned VALUE_WIDTH = 32,
    parameter int unsigned AW          = $clog2(DEPTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_we,
    input  wire logic [AW-1:0]          i_waddr,
    input  wire logic [VALUE_WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]          i_raddr_a,
    input  wire logic [AW-1:0]          i_raddr_b,
    output logic      [VALUE_WIDTH-1:0] o_rdata_a,
    output logic      [VALUE_WIDTH-1:0] o_rdata_b
);

    logic [VALUE_WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ----- rtl/core/dual_stack_shared_array.sv -----
// Top level of the dual stack block: control, cached tops and result register.
//
// Two stacks share one array of DEPTH words; the small stack grows up from
// address 0, the large stack grows down from the top address. The block takes
// one word per cycle and returns its result through an output register, so a
// new word is accepted whenever that register is empty or being drained. Each
// stack's top is held in a register and the entry below it is fetched every
// cycle on its own read port of the array, so back-to-back pops need no stall.
// The user must write the threshold through i_cfg_we/i_cfg_wdata only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module dual_stack_shared_array #(
    parameter int unsigned DEPTH       = 256,
    parameter int unsigned VALUE_WIDTH = 32,
    localparam int unsigned CNT_W      = $clog2(DEPTH + 1)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic signed [dss_pkg::DATA_W-1:0] i_cfg_wdata,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [1:0]                        i_command,
    input  wire logic signed [dss_pkg::DATA_W-1:0] i_push_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_status,
    output logic signed [dss_pkg::DATA_W-1:0]      o_popped_value,
    output logic signed [dss_pkg::DATA_W-1:0]      o_small_top,
    output logic signed [dss_pkg::DATA_W-1:0]      o_large_top,
    output logic [CNT_W-1:0]                       o_small_size,
    output logic [CNT_W-1:0]                       o_large_size,
    output logic                                   o_full_flag
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C   = CNT_W'(2);

    logic signed [dss_pkg::DATA_W-1:0] r_threshold;
    logic [CNT_W-1:0]       r_small_count, n_small_count;
    logic [CNT_W-1:0]       r_large_count, n_large_count;
    logic [VALUE_WIDTH-1:0] r_small_top, n_small_top;
    logic [VALUE_WIDTH-1:0] r_large_top, n_large_top;
    logic [VALUE_WIDTH-1:0] small_below, large_below;

    logic                   fire;
    logic                   full;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] push_word;
    logic [AW-1:0]          raddr_small, raddr_large;
    logic [CNT_W-1:0]       large_below_idx;

    dss_pkg::t_status       n_status;
    logic [VALUE_WIDTH-1:0] n_popped;

    logic                   r_out_valid;
    dss_pkg::t_status       r_status;
    logic [dss_pkg::DATA_W-1:0] r_popped, r_small_top_o, r_large_top_o;
    logic [CNT_W-1:0]       r_small_size_o, r_large_size_o;
    logic                   r_full_o;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;
    assign full       = (r_small_count + r_large_count) >= DEPTH_C;
    assign push_word  = VALUE_WIDTH'($unsigned(i_push_value));

    always_comb begin
        n_small_count = r_small_count;
        n_large_count = r_large_count;
        n_small_top   = r_small_top;
        n_large_top   = r_large_top;
        n_status      = dss_pkg::ST_OK;
        n_popped      = '0;
        mem_we        = 1'b0;
        mem_waddr     = AW'(r_small_count);
        if (fire) begin
            case (i_command)
                dss_pkg::CMD_PUSH: begin
                    if (full) begin
                        n_status = dss_pkg::ST_FULL;
                    end else if (i_push_value > r_threshold) begin
                        mem_we        = 1'b1;
                        mem_waddr     = AW'(DEPTH_C - ONE_C - r_large_count);
                        n_large_count = r_large_count + ONE_C;
                        n_large_top   = push_word;
                    end else begin
                        mem_we        = 1'b1;
                        mem_waddr     = AW'(r_small_count);
                        n_small_count = r_small_count + ONE_C;
                        n_small_top   = push_word;
                    end
                end
                dss_pkg::CMD_POP_SMALL: begin
                    if (r_small_count == '0) begin
                        n_status = dss_pkg::ST_EMPTY;
                    end else begin
                        n_popped      = r_small_top;
                        n_small_count = r_small_count - ONE_C;
                        n_small_top   = small_below;
                    end
                end
                dss_pkg::CMD_POP_LARGE: begin
                    if (r_large_count == '0) begin
                        n_status = dss_pkg::ST_EMPTY;
                    end else begin
                        n_popped      = r_large_top;
                        n_large_count = r_large_count - ONE_C;
                        n_large_top   = large_below;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // prefetch the entry below each top for the next cycle
    assign large_below_idx = DEPTH_C - n_large_count + ONE_C;
    assign raddr_small = (n_small_count >= TWO_C) ? AW'(n_small_count - TWO_C) : '0;
    assign raddr_large = (n_large_count >= TWO_C) ? AW'(large_below_idx) : '0;

    dss_mem #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .AW          (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (push_word),
        .i_raddr_a (raddr_small),
        .i_raddr_b (raddr_large),
        .o_rdata_a (small_below),
        .o_rdata_b (large_below)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= dss_pkg::THRESHOLD_RESET;
            r_small_count <= '0;
            r_large_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
            r_small_count <= n_small_count;
            r_large_count <= n_large_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_small_top <= n_small_top;
        r_large_top <= n_large_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status       <= n_status;
            r_popped       <= dss_pkg::DATA_W'(n_popped);
            r_small_top_o  <= (n_small_count == '0) ? dss_pkg::EMPTY_TOP
                                                    : dss_pkg::DATA_W'(n_small_top);
            r_large_top_o  <= (n_large_count == '0) ? dss_pkg::EMPTY_TOP
                                                    : dss_pkg::DATA_W'(n_large_top);
            r_small_size_o <= n_small_count;
            r_large_size_o <= n_large_count;
            r_full_o       <= (n_small_count + n_large_count) == DEPTH_C;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_popped_value = $signed(r_popped);
    assign o_small_top    = $signed(r_small_top_o);
    assign o_large_top    = $signed(r_large_top_o);
    assign o_small_size   = r_small_size_o;
    assign o_large_size   = r_large_size_o;
    assign o_full_flag    = r_full_o;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the two stacks that share one array.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 256;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        dss_pkg::t_status status;
        logic [31:0]      popped;
        logic [31:0]      small_top;
        logic [31:0]      large_top;
        logic [8:0]       small_size;
        logic [8:0]       large_size;
        logic             full;
    } t_stack_report;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          cfg_we = 1'b0;
    logic [31:0]   cfg_wdata = '0;
    logic          in_valid = 1'b0;
    dss_pkg::t_cmd in_cmd = dss_pkg::CMD_QUERY;
    logic [31:0]   in_value = '0;
    logic          out_ready = 1'b0;

    wire logic        o_in_ready;
    wire logic        o_out_valid;
    wire logic [1:0]  o_status;
    wire logic [31:0] o_popped_value;
    wire logic [31:0] o_small_top;
    wire logic [31:0] o_large_top;
    wire logic [8:0]  o_small_size;
    wire logic [8:0]  o_large_size;
    wire logic        o_full_flag;

    dual_stack_shared_array dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (in_cmd),
        .i_push_value  (in_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_status      (o_status),
        .o_popped_value(o_popped_value),
        .o_small_top   (o_small_top),
        .o_large_top   (o_large_top),
        .o_small_size  (o_small_size),
        .o_large_size  (o_large_size),
        .o_full_flag   (o_full_flag)
    );

    logic [31:0]        stack_shadow [DEPTH];
    logic [8:0]         small_count = '0;
    logic [8:0]         large_count = '0;
    logic signed [31:0] split_threshold = dss_pkg::THRESHOLD_RESET;

    t_stack_report expected_reports [$];
    int mismatches = 0;
    int words_sent = 0;
    int reports_checked = 0;
    int full_refusals = 0;
    int empty_refusals = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold = 0;
    int cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("tb_top failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            out_ready <= 1'b0;
            recv_hold--;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic t_stack_report apply_command(dss_pkg::t_cmd cmd, logic [31:0] value);
        t_stack_report r;
        int used;
        used = small_count + large_count;
        r.status = dss_pkg::ST_OK;
        r.popped = '0;
        case (cmd)
            dss_pkg::CMD_PUSH: begin
                if (used >= DEPTH) begin
                    r.status = dss_pkg::ST_FULL;
                    full_refusals++;
                end else if ($signed(value) > split_threshold) begin
                    stack_shadow[DEPTH - 1 - large_count] = value;
                    large_count++;
                end else begin
                    stack_shadow[small_count] = value;
                    small_count++;
                end
            end
            dss_pkg::CMD_POP_SMALL: begin
                if (small_count == 0) begin
                    r.status = dss_pkg::ST_EMPTY;
                    empty_refusals++;
                end else begin
                    small_count--;
                    r.popped = stack_shadow[small_count];
                end
            end
            dss_pkg::CMD_POP_LARGE: begin
                if (large_count == 0) begin
                    r.status = dss_pkg::ST_EMPTY;
                    empty_refusals++;
                end else begin
                    r.popped = stack_shadow[DEPTH - large_count];
                    large_count--;
                end
            end
            default: ;
        endcase
        r.small_top  = (small_count == 0) ? dss_pkg::EMPTY_TOP
                                          : stack_shadow[small_count - 1];
        r.large_top  = (large_count == 0) ? dss_pkg::EMPTY_TOP
                                          : stack_shadow[DEPTH - large_count];
        r.small_size = small_count;
        r.large_size = large_count;
        r.full       = ((small_count + large_count) == DEPTH);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : report_check
        t_stack_report want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: report with none expected, expected nothing actual status %h",
                         $time, o_status);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                reports_checked++;
                check_field("status", want.status, o_status);
                check_field("popped_value", want.popped, o_popped_value);
                check_field("small_top", want.small_top, o_small_top);
                check_field("large_top", want.large_top, o_large_top);
                check_field("small_size", want.small_size, o_small_size);
                check_field("large_size", want.large_size, o_large_size);
                check_field("full_flag", want.full, o_full_flag);
            end
        end
    end

    task automatic send_word(input dss_pkg::t_cmd cmd, input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            in_cmd   = dss_pkg::t_cmd'($urandom);
            in_value = $urandom;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_cmd   = cmd;
        in_value = value;
        do @(posedge i_clk); while (!o_in_ready);
        expected_reports.push_back(apply_command(cmd, value));
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic signed [31:0] value);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = value;
        split_threshold = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return split_threshold;
            1: return split_threshold + 1;
            2: return split_threshold - 1;
            3: case ($urandom_range(3))
                   0: return 32'h8000_0000;
                   1: return 32'h7FFF_FFFF;
                   2: return 32'hFFFF_FFFF;
                   default: return 32'h0;
               endcase
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_stacks();
        send_word(dss_pkg::CMD_POP_SMALL, 32'h1234_5678);
        send_word(dss_pkg::CMD_POP_LARGE, 32'hFFFF_FFFF);
        send_word(dss_pkg::CMD_QUERY, 32'h0);
    endtask

    task automatic test_threshold_split();
        send_word(dss_pkg::CMD_PUSH, 32'd1000);
        send_word(dss_pkg::CMD_PUSH, 32'd1001);
        send_word(dss_pkg::CMD_PUSH, 32'hFFFF_FFFF);
        send_word(dss_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        send_word(dss_pkg::CMD_PUSH, 32'h8000_0000);
        send_word(dss_pkg::CMD_QUERY, 32'h5555_AAAA);
        send_word(dss_pkg::CMD_POP_SMALL, 32'h0);
        send_word(dss_pkg::CMD_POP_LARGE, 32'h0);
        send_word(dss_pkg::CMD_POP_SMALL, 32'h0);
        send_word(dss_pkg::CMD_POP_LARGE, 32'h0);
        send_word(dss_pkg::CMD_POP_SMALL, 32'h0);
        send_word(dss_pkg::CMD_POP_SMALL, 32'h0);
    endtask

    task automatic test_threshold_extremes();
        write_threshold(32'sh8000_0000);
        send_word(dss_pkg::CMD_PUSH, 32'h8000_0000);
        send_word(dss_pkg::CMD_PUSH, 32'h8000_0001);
        send_word(dss_pkg::CMD_PUSH, 32'h0);
        write_threshold(32'sh7FFF_FFFF);
        send_word(dss_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        send_word(dss_pkg::CMD_QUERY, 32'h0);
        send_word(dss_pkg::CMD_POP_LARGE, 32'h0);
        send_word(dss_pkg::CMD_POP_LARGE, 32'h0);
        send_word(dss_pkg::CMD_POP_SMALL, 32'h0);
        send_word(dss_pkg::CMD_POP_SMALL, 32'h0);
    endtask

    task automatic test_fill_and_overflow();
        write_threshold(32'sd0);
        recv_hold = 300;
        while (small_count + large_count < DEPTH) send_word(dss_pkg::CMD_PUSH, pick_value());
        send_word(dss_pkg::CMD_PUSH, 32'h7FFF_FFFF);
        send_word(dss_pkg::CMD_PUSH, 32'h8000_0000);
        send_word(dss_pkg::CMD_QUERY, 32'h0);
        send_word(dss_pkg::CMD_POP_LARGE, 32'h0);
        send_word(dss_pkg::CMD_PUSH, $urandom);
        send_word(dss_pkg::CMD_PUSH, $urandom);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int send_pct, recv_pct, count,
                                       input logic signed [31:0] threshold);
        int run_left;
        int push_pct;
        int r;
        write_threshold(threshold);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        run_left = 0;
        push_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(16, 96);
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 15;
                    default: push_pct = 50;
                endcase
            end
            run_left--;
            if (n == count / 2) wait_drained();
            r = $urandom_range(99);
            if (r < push_pct)
                send_word(dss_pkg::CMD_PUSH, pick_value());
            else if (r < 97)
                send_word($urandom_range(1) ? dss_pkg::CMD_POP_LARGE : dss_pkg::CMD_POP_SMALL,
                          $urandom);
            else
                send_word(dss_pkg::CMD_QUERY, $urandom);
        end
    endtask

    initial begin
        send_idle_pct = 23;
        recv_idle_pct = 80;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_stacks();
        test_threshold_split();
        test_threshold_extremes();
        test_fill_and_overflow();
        test_random_traffic(23, 80, 260, 32'sd1000);
        test_random_traffic(80, 23, 260, $urandom);
        test_random_traffic(0, 0, 260, -32'sd200);

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("%0d words sent, %0d reports checked, %0d mismatches",
                 words_sent, reports_checked, mismatches);
        $display("covered pushes on both sides of the threshold, %0d refused pushes,",
                 full_refusals);
        $display("%0d pops of empty stacks", empty_refusals);
        if (mismatches == 0 && expected_reports.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
